@@ src/lse_pkg.sv @@
// Shared types, constants and helpers for the LSB stego extractor.
package lse_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned WidthW  = 4;   // holds 1..8
	localparam int unsigned PendW   = 3;   // holds 0..7
	localparam int unsigned AccW    = 7;   // carried bits after a group is emitted
	localparam int unsigned MergeW  = 15;  // carry bits plus a fresh chunk

	localparam logic [WidthW-1:0] WidthMin = 4'd1;
	localparam logic [WidthW-1:0] WidthMax = 4'd8;

	typedef logic [ByteW-1:0] byte_t;

	// Count the run of ones from bit 0 and add one, saturating at eight.
	function automatic logic [WidthW-1:0] header_width(input byte_t h);
		logic [WidthW-1:0] w;
		logic              run;
		w   = WidthMin;
		run = 1'b1;
		for (int i = 0; i < 7; i++) begin
			run = run & h[i];
			if (run) begin
				w = w + WidthMin;
			end
		end
		return w;
	endfunction

	// Mask of the low w bits of a byte, w in 1..8.
	function automatic byte_t low_mask(input logic [WidthW-1:0] w);
		byte_t m;
		for (int i = 0; i < ByteW; i++) begin
			m[i] = (WidthW'(i) < w);
		end
		return m;
	endfunction

endpackage

@@ src/lsb_stego_extract.sv @@
// Top level of the LSB stego extractor: header decode, bit packing, output register.
//
// Usage:
//   Slave channel (s_*) takes one cover-image byte per word. The first word of
//   an image is a header: the run of ones from bit 0, plus one (at most 8),
//   sets how many low bits each later byte carries. s_tlast marks the final
//   image byte.
//   Master channel (m_*) gives recovered message bytes. m_tuser is byte_valid,
//   m_tlast is message_end. A word is produced whenever eight bits complete,
//   and always for the byte marked last (with m_tuser low if no byte finished).
//   Trailing partial bits are dropped at the end of an image and the block
//   waits for a new header.
// Latency and throughput:
//   Results pass the single output register and show on the master side in the next cycle.
//   One input word per cycle, unless a result waits while m_tready is low.
// Reset:
//   arst_n clears the output valid flag and returns to waiting for a header.
// Stall:
//   While m_tready is low and a result waits, s_tready drops; an input word is
//   still taken in the same cycle the waiting result is taken.
module lsb_stego_extract
	import lse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// slave side
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] stego_byte
	input  logic       s_tlast,   // last_byte
	// master side
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic       m_tuser,   // [0] byte_valid
	output logic       m_tlast    // message_end
);

	logic              awaiting_q;
	logic [WidthW-1:0] width_q;
	logic [AccW-1:0]   acc_q;
	logic [PendW-1:0]  pend_q;

	logic              out_valid_q;
	byte_t             out_data_q;
	logic              out_user_q;
	logic              out_last_q;

	logic              take;
	byte_t             chunk;
	logic [MergeW-1:0] merged;
	logic [WidthW:0]   pend_sum;
	logic              full;

	logic              nxt_awaiting;
	logic [WidthW-1:0] nxt_width;
	logic [AccW-1:0]   nxt_acc;
	logic [PendW-1:0]  nxt_pend;
	byte_t             res_data;
	logic              res_valid;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	// Append the chunk above the carried bits.
	assign chunk    = s_tdata & low_mask(width_q);
	assign merged   = MergeW'(acc_q) | (MergeW'(chunk) << pend_q);
	assign pend_sum = (WidthW+1)'(pend_q) + (WidthW+1)'(width_q);
	assign full     = pend_sum >= (WidthW+1)'(ByteW);

	always_comb begin
		nxt_awaiting = awaiting_q;
		nxt_width    = width_q;
		nxt_acc      = acc_q;
		nxt_pend     = pend_q;
		res_data     = '0;
		res_valid    = 1'b0;
		if (awaiting_q) begin
			nxt_awaiting = 1'b0;
			nxt_width    = header_width(s_tdata);
			nxt_acc      = '0;
			nxt_pend     = '0;
		end else if (full) begin
			res_data  = merged[ByteW-1:0];
			res_valid = 1'b1;
			nxt_acc   = merged[ByteW +: AccW];
			nxt_pend  = PendW'(pend_sum - (WidthW+1)'(ByteW));
		end else begin
			nxt_acc  = merged[AccW-1:0];
			nxt_pend = PendW'(pend_sum);
		end
		// drop partial bits and re-arm at end of image
		if (s_tlast) begin
			nxt_awaiting = 1'b1;
			nxt_width    = WidthMin;
			nxt_acc      = '0;
			nxt_pend     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			width_q    <= WidthMin;
			acc_q      <= '0;
			pend_q     <= '0;
		end else if (take) begin
			awaiting_q <= nxt_awaiting;
			width_q    <= nxt_width;
			acc_q      <= nxt_acc;
			pend_q     <= nxt_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res_valid || s_tlast;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= res_data;
			out_user_q <= res_valid;
			out_last_q <= s_tlast;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q >= WidthMin) && (width_q <= WidthMax))
		else $error("embedded width out of range");

	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
		else $error("result without a byte outside end of image");

	a_rearm_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && s_tlast) |=> (awaiting_q && (pend_q == '0) && (acc_q == '0)
			&& (width_q == WidthMin)))
		else $error("block not re-armed after last byte");

	a_header_gives_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(take && awaiting_q) |=> (m_tvalid == $past(s_tlast)) && !m_tuser)
		else $error("header byte produced a data word");

endmodule
